[rtl/ssm_pkg.sv]
// Shared types and constants for the sorted stream merge block.
// No dependencies; used by ssm_front, ssm_back and sorted_stream_merge.
package ssm_pkg;

  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;

  localparam logic LIST_A = 1'b0;
  localparam logic LIST_B = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_A = 2'd0,
    CMD_PUSH_B = 2'd1,
    CMD_END_A  = 2'd2,
    CMD_END_B  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic               list;
    logic               is_end;
    logic               last;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic               overflow;
    logic               merge_last;
    logic               has_value;
    logic               from_list;
    logic [VALUE_W-1:0] value;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

[rtl/ssm_front.sv]
// Input side of the merge: decodes each incoming command into an item
// and holds it in a two-entry queue for the merge engine. Uses ssm_pkg.
module ssm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ssm_pkg::VALUE_W-1:0] s_tdata,
  input  logic [ssm_pkg::CMD_W-1:0]   s_tuser,
  input  logic                        s_tlast,
  output logic                        item_valid,
  input  logic                        item_ready,
  output ssm_pkg::item_t              item
);

  ssm_pkg::item_t fifo [2];
  ssm_pkg::item_t decoded;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  always_comb begin
    decoded       = '0;
    decoded.value = s_tdata;
    decoded.last  = s_tlast;
    case (ssm_pkg::cmd_t'(s_tuser))
      ssm_pkg::CMD_PUSH_A: begin
        decoded.list   = ssm_pkg::LIST_A;
        decoded.is_end = 1'b0;
      end
      ssm_pkg::CMD_PUSH_B: begin
        decoded.list   = ssm_pkg::LIST_B;
        decoded.is_end = 1'b0;
      end
      ssm_pkg::CMD_END_A: begin
        decoded.list   = ssm_pkg::LIST_A;
        decoded.is_end = 1'b1;
      end
      ssm_pkg::CMD_END_B: begin
        decoded.list   = ssm_pkg::LIST_B;
        decoded.is_end = 1'b1;
      end
      default: begin
        decoded.list   = ssm_pkg::LIST_A;
        decoded.is_end = 1'b1;
      end
    endcase
  end

  assign s_tready   = (fill != 2'd2);
  assign item_valid = (fill != 2'd0);
  assign item       = fifo[rd_ptr];
  assign push       = s_tvalid && s_tready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= decoded;
    end
  end

endmodule

[rtl/ssm_back.sv]
// Merge engine: per-list element memories, head compare and result register.
// Takes decoded items from ssm_front; uses ssm_pkg.
module ssm_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  ssm_pkg::item_t              item,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ssm_pkg::VALUE_W-1:0] m_tdata,
  output logic [2:0]                  m_tuser,
  output logic                        m_tlast
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  ssm_pkg::state_t state;
  ssm_pkg::state_t state_next;

  logic [ssm_pkg::VALUE_W-1:0] mem_a [QUEUE_DEPTH];
  logic [ssm_pkg::VALUE_W-1:0] mem_b [QUEUE_DEPTH];
  logic [ssm_pkg::VALUE_W-1:0] rd_a;
  logic [ssm_pkg::VALUE_W-1:0] rd_b;

  logic [PTR_W-1:0] head_a, tail_a, head_b, tail_b;
  logic [PTR_W-1:0] head_a_next, head_b_next;
  logic [CNT_W-1:0] count_a, count_b;
  logic             ended_a, ended_b;

  logic ne_a, ne_b, both, b_le_a;
  logic take_a, take_b, done_after, all_done, full, slot_free;
  logic wr_a, wr_b, pop_a, pop_b, mark_end_a, mark_end_b, do_clear, load_out;
  ssm_pkg::result_t res;

  assign slot_free = !m_tvalid || m_tready;
  assign ne_a      = (count_a != '0);
  assign ne_b      = (count_b != '0);
  assign both      = ne_a && ne_b;
  assign b_le_a    = ($signed(rd_b) <= $signed(rd_a));

  assign take_b = (both && b_le_a) ||
                  (!both && ne_b && ended_a && (ended_b || count_b > CNT_W'(1)));
  assign take_a = (both && !b_le_a) ||
                  (!both && ne_a && ended_b && (ended_a || count_a > CNT_W'(1)));

  assign done_after = ended_a && ended_b &&
                      (!ne_a || (take_a && count_a == CNT_W'(1))) &&
                      (!ne_b || (take_b && count_b == CNT_W'(1)));
  assign all_done   = ended_a && ended_b && !ne_a && !ne_b;

  assign full = (item.list == ssm_pkg::LIST_B) ? (ended_b || count_b == FULL_CNT)
                                               : (ended_a || count_a == FULL_CNT);

  always_comb begin
    item_ready = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    pop_a      = 1'b0;
    pop_b      = 1'b0;
    mark_end_a = 1'b0;
    mark_end_b = 1'b0;
    do_clear   = 1'b0;
    load_out   = 1'b0;
    res        = '0;
    case (state)
      ssm_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item.is_end) begin
            item_ready = 1'b1;
            mark_end_a = (item.list == ssm_pkg::LIST_A);
            mark_end_b = (item.list == ssm_pkg::LIST_B);
          end else if (full) begin
            item_ready    = slot_free;
            load_out      = slot_free;
            res.from_list = item.list;
            res.overflow  = 1'b1;
          end else begin
            item_ready = 1'b1;
            wr_a       = (item.list == ssm_pkg::LIST_A);
            wr_b       = (item.list == ssm_pkg::LIST_B);
            mark_end_a = wr_a && item.last;
            mark_end_b = wr_b && item.last;
          end
        end
      end
      ssm_pkg::ST_DRAIN: begin
        if (take_a || take_b) begin
          load_out       = slot_free;
          pop_a          = take_a && slot_free;
          pop_b          = take_b && slot_free;
          res.value      = take_b ? rd_b : rd_a;
          res.from_list  = take_b ? ssm_pkg::LIST_B : ssm_pkg::LIST_A;
          res.has_value  = 1'b1;
          res.merge_last = done_after;
          do_clear       = slot_free && done_after;
        end else if (all_done) begin
          load_out       = slot_free;
          res.merge_last = 1'b1;
          do_clear       = slot_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ssm_pkg::ST_IDLE: begin
        if (item_valid && item_ready && !res.overflow) begin
          state_next = ssm_pkg::ST_DRAIN;
        end
      end
      ssm_pkg::ST_DRAIN: begin
        if (take_a || take_b) begin
          state_next = (slot_free && done_after) ? ssm_pkg::ST_IDLE : ssm_pkg::ST_DRAIN;
        end else if (all_done) begin
          state_next = slot_free ? ssm_pkg::ST_IDLE : ssm_pkg::ST_DRAIN;
        end else begin
          state_next = ssm_pkg::ST_IDLE;
        end
      end
      default: state_next = ssm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (do_clear) begin
      head_a_next = '0;
      head_b_next = '0;
    end else begin
      head_a_next = pop_a ? ((head_a == LAST_PTR) ? '0 : head_a + PTR_W'(1)) : head_a;
      head_b_next = pop_b ? ((head_b == LAST_PTR) ? '0 : head_b + PTR_W'(1)) : head_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssm_pkg::ST_IDLE;
      head_a   <= '0;
      head_b   <= '0;
      tail_a   <= '0;
      tail_b   <= '0;
      count_a  <= '0;
      count_b  <= '0;
      ended_a  <= 1'b0;
      ended_b  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      head_a <= head_a_next;
      head_b <= head_b_next;
      if (do_clear) begin
        tail_a  <= '0;
        tail_b  <= '0;
        count_a <= '0;
        count_b <= '0;
        ended_a <= 1'b0;
        ended_b <= 1'b0;
      end else begin
        if (wr_a) begin
          tail_a  <= (tail_a == LAST_PTR) ? '0 : tail_a + PTR_W'(1);
          count_a <= count_a + CNT_W'(1);
        end else if (pop_a) begin
          count_a <= count_a - CNT_W'(1);
        end
        if (wr_b) begin
          tail_b  <= (tail_b == LAST_PTR) ? '0 : tail_b + PTR_W'(1);
          count_b <= count_b + CNT_W'(1);
        end else if (pop_b) begin
          count_b <= count_b - CNT_W'(1);
        end
        if (mark_end_a) begin
          ended_a <= 1'b1;
        end
        if (mark_end_b) begin
          ended_b <= 1'b1;
        end
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= res.value;
      m_tuser <= {res.overflow, res.has_value, res.from_list};
      m_tlast <= res.merge_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[tail_a] <= item.value;
    end
    if (wr_a && tail_a == head_a_next) begin
      rd_a <= item.value;
    end else begin
      rd_a <= mem_a[head_a_next];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[tail_b] <= item.value;
    end
    if (wr_b && tail_b == head_b_next) begin
      rd_b <= item.value;
    end else begin
      rd_b <= mem_b[head_b_next];
    end
  end

endmodule

[rtl/sorted_stream_merge.sv]
// Sorted stream merge: two ascending signed lists in, one ascending stream out.
// Instantiates ssm_front and ssm_back; uses ssm_pkg.
//
// Input channel (s_*): one command per item. s_tuser selects push A, push B,
// end A or end B; s_tdata carries the element, s_tlast marks a pushed element
// as the last of its list. A two-entry queue decouples input from the engine.
// Output channel (m_*): merged elements in ascending order, B first on ties.
// m_tuser flags the list of origin, whether a value is present and a dropped
// push; m_tlast marks the final result of a merge, after which the block
// starts a new pair of lists.
// Sequence: the engine takes in an item, then releases its results one per cycle
// while the receiver accepts them, then closes unless its last result ends the
// merge; it takes no new item before it is back in idle. A dropped push gives
// its single result from idle. An item's first result waits for its store and
// the registered head read. The element memories have one read port each, read
// one entry per cycle, which sets this pace. Reset clears the queues, list
// state and output valid; element memories are not cleared. A stalled
// receiver holds the output register, the engine waits once it has a result,
// and the input queue fills and drops s_tready.
module sorted_stream_merge #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [ssm_pkg::VALUE_W-1:0] s_tdata,   // in_value
  input  logic [ssm_pkg::CMD_W-1:0]   s_tuser,   // cmd
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [ssm_pkg::VALUE_W-1:0] m_tdata,   // out_value
  output logic [2:0]                  m_tuser,   // [2] overflow, [1] has_value, [0] from_list
  output logic                        m_tlast
);

  logic           item_valid;
  logic           item_ready;
  ssm_pkg::item_t item;

  ssm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  ssm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

[rtl/ssm_checker.sv]
// Port-level checks for the sorted stream merge output channel.
// Attached to sorted_stream_merge by the bind at the end of this file.
module ssm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_overflow_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> !m_tuser[1] && !m_tlast)
    else $error("overflow result carries a value or end mark");

  a_empty_merge: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] && !m_tuser[2] |-> m_tlast && !m_tuser[0])
    else $error("valueless result that is neither overflow nor empty merge end");

  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata == 32'd0)
    else $error("nonzero data on valueless result");

endmodule

bind sorted_stream_merge ssm_checker u_ssm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
